// File: rtl/upct_pkg.sv
// Shared types and constants for the UDP peer connection table.
// Depends on nothing; every module of the block imports it.
package upct_pkg;

   // Operation codes carried in the request beat
   localparam logic [1:0] OP_MATCH  = 2'd0;
   localparam logic [1:0] OP_OPEN   = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_LOOKUP = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_EXISTING = 3'd0;
   localparam logic [2:0] ST_NEW      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_INVALID  = 3'd3;
   localparam logic [2:0] ST_RESFAIL  = 3'd4;

   // Register indexes on the configuration port
   localparam logic REG_DEFAULT_PORT = 1'b0;
   localparam logic REG_SUBNET_BASE  = 1'b1;

   localparam logic [15:0] RESET_PORT = 16'd3819;
   localparam logic [31:0] RESET_BASE = 32'hC0A8_6400;
   localparam logic [31:0] OCTET_MASK = 32'h0000_00FF;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] peer_addr;
      logic [15:0] peer_udp_port;
      logic [7:0]  node_id;
      logic [3:0]  slot_handle;
      logic        resolve_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [31:0] entry_addr;
      logic [15:0] entry_port;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
   } entry_type;

   typedef struct packed {
      logic [15:0] default_port;
      logic [31:0] subnet_base;
   } cfg_type;

endpackage

// File: rtl/upct_csr.sv
// APB-style configuration registers: default port and subnet base.
// Depends on upct_pkg for the register indexes, reset values and cfg_type.
module upct_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output upct_pkg::cfg_type    cfg
);
   import upct_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (paddr[2])
            REG_DEFAULT_PORT: cfg_in.default_port = pwdata[15:0];
            REG_SUBNET_BASE:  cfg_in.subnet_base  = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DEFAULT_PORT: prdata = {16'd0, cfg_ff.default_port};
         REG_SUBNET_BASE:  prdata = cfg_ff.subnet_base;
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_port <= RESET_PORT;
         cfg_ff.subnet_base  <= RESET_BASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/upct_mem.sv
// Peer entry store: one write port, one registered read port.
// Depends on upct_pkg for entry_type; unwritten entries read as free (zero).
module upct_mem #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              wr_en,
   input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_idx,
   input  upct_pkg::entry_type                               wr_entry,
   input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_idx,
   output upct_pkg::entry_type                               rd_entry
);
   import upct_pkg::*;

   entry_type             mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]  valid_ff;
   entry_type             rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff[rd_idx]) begin
         rd_entry_ff <= mem[rd_idx];
      end else begin
         rd_entry_ff <= '0;
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// File: rtl/udp_peer_connection_table.sv
// UDP peer connection table: a NUM_SLOTS-entry store of (IPv4 address, UDP
// port) pairs, where an all-zero pair marks a free slot. One request beat
// in gives one response beat out. A receive match or an open by node scans
// the store through its single read port, one entry per cycle with the
// read pipelined against the compare, and stops early when an entry hits.
// One request is worked on at a time; the next one is accepted while the
// previous response still waits on rsp_stall. Registers: offset 0 default
// port, offset 4 subnet base; write them only while idle.
module udp_peer_connection_table #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  upct_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output upct_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import upct_pkg::*;

   localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_LOOK = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   rsp_type         res_ff, res_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [IDXW-1:0] issue_idx_ff, issue_idx_in;
   logic            issue_live_ff, issue_live_in;
   logic [IDXW-1:0] eval_idx_ff, eval_idx_in;
   logic            eval_live_ff, eval_live_in;
   logic            have_free_ff, have_free_in;
   logic [IDXW-1:0] free_idx_ff, free_idx_in;

   cfg_type         cfg;
   logic            accept;
   logic            handle_ok;
   logic            wr_en;
   logic [IDXW-1:0] wr_idx;
   entry_type       wr_entry;
   logic [IDXW-1:0] rd_idx;
   entry_type       rd_entry;
   logic            hit;
   logic            is_free;
   logic            take_free;
   logic            free_now;
   logic [IDXW-1:0] free_idx_now;
   logic            rsp_open;

   upct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   upct_mem #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry)
   );

   // Take a request only when idle; results park in the output register.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Check the handle on the incoming beat; only the accept cycle uses it
   assign handle_ok = (32'(req_data.slot_handle) < NUM_SLOTS);

   // While idle, aim the read port at the handle so a lookup has its entry
   // in the cycle after the accept; during a scan, walk the slots in order.
   assign rd_idx = (state_ff == S_SCAN) ? issue_idx_ff : req_data.slot_handle[IDXW-1:0];

   // Compare the entry returned for eval_idx_ff against the held request
   always_comb begin
      if (req_ff.op == OP_MATCH) begin
         hit = (rd_entry.addr == req_ff.peer_addr) && (rd_entry.port == req_ff.peer_udp_port);
      end else begin
         hit = ((rd_entry.addr & OCTET_MASK) == {24'd0, req_ff.node_id});
      end
      is_free      = (rd_entry == '0);
      // Receive keeps the first free slot, open keeps the last one
      take_free    = is_free && ((req_ff.op == OP_OPEN) || !have_free_ff);
      free_now     = have_free_ff || is_free;
      free_idx_now = take_free ? eval_idx_ff : free_idx_ff;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      issue_idx_in  = issue_idx_ff;
      issue_live_in = issue_live_ff;
      eval_idx_in   = eval_idx_ff;
      eval_live_in  = eval_live_ff;
      have_free_in  = have_free_ff;
      free_idx_in   = free_idx_ff;
      wr_en         = 1'b0;
      wr_idx        = req_data.slot_handle[IDXW-1:0];
      wr_entry      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in            = req_data;
               res_in            = '0;
               res_in.slot       = req_data.slot_handle;
               res_in.status     = ST_EXISTING;
               issue_idx_in      = '0;
               issue_live_in     = 1'b1;
               eval_live_in      = 1'b0;
               have_free_in      = 1'b0;
               free_idx_in       = '0;
               if (req_data.op == OP_MATCH || req_data.op == OP_OPEN) begin
                  state_in = S_SCAN;
               end else if (!handle_ok) begin
                  res_in.status = ST_INVALID;
                  state_in      = S_DONE;
               end else if (req_data.op == OP_DELETE) begin
                  // Clear the slot right away; zero reads as free
                  wr_en    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end

         S_SCAN: begin
            // Advance the read pointer; the compare follows it in the next cycle
            eval_live_in = issue_live_ff;
            eval_idx_in  = issue_idx_ff;
            if (issue_live_ff) begin
               issue_idx_in  = issue_idx_ff + 1'b1;
               issue_live_in = (issue_idx_ff != LAST_IDX);
            end
            if (eval_live_ff) begin
               have_free_in = free_now;
               free_idx_in  = free_idx_now;
               if (hit) begin
                  res_in.status = ST_EXISTING;
                  res_in.slot   = 4'(eval_idx_ff);
                  state_in      = S_DONE;
               end else if (eval_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
                  if (!free_now) begin
                     res_in.status = ST_FULL;
                     res_in.slot   = 4'd0;
                  end else begin
                     wr_en       = 1'b1;
                     wr_idx      = free_idx_now;
                     res_in.slot = 4'(free_idx_now);
                     if (req_ff.op == OP_MATCH) begin
                        wr_entry.addr = req_ff.peer_addr;
                        wr_entry.port = req_ff.peer_udp_port;
                        res_in.status = ST_NEW;
                     end else if (req_ff.resolve_ok) begin
                        wr_entry.addr = cfg.subnet_base | {24'd0, req_ff.node_id};
                        wr_entry.port = cfg.default_port;
                        res_in.status = ST_NEW;
                     end else begin
                        // Resolution failed: drop the slot back to free
                        res_in.status = ST_RESFAIL;
                     end
                  end
               end
            end
         end

         S_LOOK: begin
            res_in.entry_addr = rd_entry.addr;
            res_in.entry_port = rd_entry.port;
            state_in          = S_DONE;
         end

         S_DONE: begin
            // Hold the result until the output register is free
            if (rsp_open) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         issue_live_ff <= 1'b0;
         eval_live_ff  <= 1'b0;
         have_free_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_live_ff <= issue_live_in;
         eval_live_ff  <= eval_live_in;
         have_free_ff  <= have_free_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      issue_idx_ff <= issue_idx_in;
      eval_idx_ff  <= eval_idx_in;
      free_idx_ff  <= free_idx_in;
   end

endmodule

// File: bench/udp_peer_connection_table_tb.sv
// Self-checking bench for the UDP peer connection table: directed, config, random, backpressure and no-idle tests.
// Depends on upct_pkg and udp_peer_connection_table only; a local table mirror predicts each beat.
`timescale 1ns / 1ps

module udp_peer_connection_table_tb;
   import upct_pkg::*;

   localparam int SLOTS = 8;
   localparam int IDXW = $clog2(SLOTS);
   localparam int PEER_POOL = 12;
   localparam int NODE_POOL = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Mirror of the block: peer entries plus the two registers
   entry_type   peer_tab [SLOTS];
   cfg_type     cfg_shadow;
   rsp_type     pending_rsp [$];

   entry_type   peer_pool [PEER_POOL];
   logic [7:0]  node_pool [NODE_POOL];

   int          mismatch_count = 0;
   int          stall_left = 0;
   bit          idle_off = 1'b0;   // no idling on either side once set
   bit          hold_off = 1'b0;   // long receiver hold, owned by the backpressure test

   udp_peer_connection_table #(.NUM_SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard limit; the slowest legal run needs well under a millisecond
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Table mirror: compute the response beat for one request beat and
   // apply its side effects to the mirrored entries.
   // ------------------------------------------------------------------
   function automatic rsp_type table_outcome(input req_type r);
      rsp_type     o;
      bit          hit;
      bit          have_free;
      int unsigned free_idx;
      o = '0;
      hit = 1'b0;
      have_free = 1'b0;
      free_idx = 0;
      case (r.op)
         OP_MATCH: begin
            // Exact pair match wins; otherwise remember the first free slot
            // seen before any hit.
            for (int i = 0; i < SLOTS; i++) begin
               if (!hit) begin
                  if (peer_tab[i].addr == r.peer_addr && peer_tab[i].port == r.peer_udp_port) begin
                     hit = 1'b1;
                     o.slot = 4'(i);
                  end else if (!have_free && peer_tab[i] == '0) begin
                     have_free = 1'b1;
                     free_idx = i;
                  end
               end
            end
            if (hit) begin
               o.status = ST_EXISTING;
            end else if (have_free) begin
               peer_tab[free_idx].addr = r.peer_addr;
               peer_tab[free_idx].port = r.peer_udp_port;
               o.status = ST_NEW;
               o.slot = 4'(free_idx);
            end else begin
               o.status = ST_FULL;
            end
         end
         OP_OPEN: begin
            // Match on the low octet only; allocation takes the last free slot.
            for (int i = 0; i < SLOTS; i++) begin
               if (!hit) begin
                  if ((peer_tab[i].addr & OCTET_MASK) == {24'd0, r.node_id}) begin
                     hit = 1'b1;
                     o.slot = 4'(i);
                  end else if (peer_tab[i] == '0) begin
                     have_free = 1'b1;
                     free_idx = i;
                  end
               end
            end
            if (hit) begin
               o.status = ST_EXISTING;
            end else if (!have_free) begin
               o.status = ST_FULL;
            end else if (r.resolve_ok) begin
               peer_tab[free_idx].addr = cfg_shadow.subnet_base | {24'd0, r.node_id};
               peer_tab[free_idx].port = cfg_shadow.default_port;
               o.status = ST_NEW;
               o.slot = 4'(free_idx);
            end else begin
               peer_tab[free_idx] = '0;
               o.status = ST_RESFAIL;
               o.slot = 4'(free_idx);
            end
         end
         default: begin
            o.slot = r.slot_handle;
            if (r.slot_handle >= SLOTS) begin
               o.status = ST_INVALID;
            end else if (r.op == OP_DELETE) begin
               peer_tab[r.slot_handle[IDXW-1:0]] = '0;
               o.status = ST_EXISTING;
            end else begin
               o.entry_addr = peer_tab[r.slot_handle[IDXW-1:0]].addr;
               o.entry_port = peer_tab[r.slot_handle[IDXW-1:0]].port;
               o.status = ST_EXISTING;
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Monitor: predict on every accepted request beat, compare on every
   // accepted response beat. Push before pop so a same-edge pair works.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_rsp.push_back(table_outcome(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response beat with none pending", 32'(rsp_data.slot), 32'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.slot !== want.slot)
                  report_mismatch("slot", 32'(rsp_data.slot), 32'(want.slot));
               if (rsp_data.entry_addr !== want.entry_addr)
                  report_mismatch("entry_addr", rsp_data.entry_addr, want.entry_addr);
               if (rsp_data.entry_port !== want.entry_port)
                  report_mismatch("entry_port", 32'(rsp_data.entry_port),
                                  32'(want.entry_port));
            end
         end
      end
   end

   // Receiver: short random stall bursts, or a long hold while hold_off is up
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!idle_off && $urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Sender. Called and returning at a falling edge; valid stays up
   // across back-to-back beats so it is never dropped and raised in one step.
   // ------------------------------------------------------------------
   task automatic send_req(input req_type r);
      if (!idle_off && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted beat has come back
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic csr_access(input logic idx, input logic write, input logic [31:0] val);
      logic [31:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (write) begin
         if (idx == REG_DEFAULT_PORT)
            cfg_shadow.default_port = val[15:0];
         else
            cfg_shadow.subnet_base = val;
      end else begin
         // compare only the register's own width
         if (idx == REG_DEFAULT_PORT) begin
            want = {16'd0, cfg_shadow.default_port};
            if (prdata[15:0] !== want[15:0])
               report_mismatch("default_port readback", prdata, want);
         end else begin
            want = cfg_shadow.subnet_base;
            if (prdata !== want)
               report_mismatch("subnet_base readback", prdata, want);
         end
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Registers change only with the block idle
   task automatic set_config(input logic [15:0] port, input logic [31:0] base);
      drain;
      csr_access(REG_DEFAULT_PORT, 1'b1, {16'd0, port});
      csr_access(REG_SUBNET_BASE, 1'b1, base);
      csr_access(REG_DEFAULT_PORT, 1'b0, '0);
      csr_access(REG_SUBNET_BASE, 1'b0, '0);
   endtask

   function automatic req_type mk_req(input logic [1:0] op, input logic [31:0] addr,
                                      input logic [15:0] port, input logic [7:0] node,
                                      input logic [3:0] handle, input logic ok);
      req_type r;
      r.op = op;
      r.peer_addr = addr;
      r.peer_udp_port = port;
      r.node_id = node;
      r.slot_handle = handle;
      r.resolve_ok = ok;
      return r;
   endfunction

   // Fresh peers and node IDs for a phase: some collide with what opens
   // write, some are the odd zero forms, the rest are random.
   task automatic refresh_pools;
      for (int i = 0; i < PEER_POOL; i++) begin
         peer_pool[i].addr = $urandom;
         peer_pool[i].port = 16'($urandom);
      end
      peer_pool[0].addr = '0;
      peer_pool[1].port = '0;
      peer_pool[2] = '0;
      for (int i = 0; i < NODE_POOL; i++)
         node_pool[i] = 8'($urandom);
      node_pool[0] = '0;
      node_pool[1] = peer_pool[4].addr[7:0];
      peer_pool[3].addr = cfg_shadow.subnet_base | {24'd0, node_pool[2]};
      peer_pool[3].port = cfg_shadow.default_port;
   endtask

   // Mostly pooled peers and live handles so hits, frees and refills
   // keep happening; the rest is raw noise over the whole field range.
   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      r.peer_addr = $urandom;
      r.peer_udp_port = 16'($urandom);
      r.node_id = 8'($urandom);
      r.slot_handle = 4'($urandom);
      r.resolve_ok = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 7)
         r.op = OP_MATCH;
      else if (pick < 12)
         r.op = OP_OPEN;
      else if (pick < 16)
         r.op = OP_DELETE;
      else
         r.op = OP_LOOKUP;
      if ($urandom_range(0, 9) < 7) begin
         pick = $urandom_range(0, PEER_POOL - 1);
         r.peer_addr = peer_pool[pick].addr;
         r.peer_udp_port = peer_pool[pick].port;
         r.node_id = node_pool[$urandom_range(0, NODE_POOL - 1)];
      end
      if ($urandom_range(0, 7) != 0)
         r.slot_handle = 4'($urandom_range(0, SLOTS - 1));
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed;
      // Fresh table, reset registers
      send_req(mk_req(OP_LOOKUP, '0, '0, '0, 4'd0, 1'b1));
      // all-zero peer lands on the first free slot as existing
      send_req(mk_req(OP_MATCH, '0, '0, '0, '0, 1'b1));
      send_req(mk_req(OP_MATCH, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, 1'b1));
      send_req(mk_req(OP_MATCH, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, 1'b0));
      // node zero matches a free slot
      send_req(mk_req(OP_OPEN, '0, '0, 8'd0, '0, 1'b1));
      send_req(mk_req(OP_OPEN, '0, '0, 8'hFF, '0, 1'b1));
      send_req(mk_req(OP_OPEN, '0, '0, 8'd5, '0, 1'b1));
      send_req(mk_req(OP_OPEN, '0, '0, 8'd5, '0, 1'b0));
      // failed resolution frees the slot again
      send_req(mk_req(OP_OPEN, '0, '0, 8'd6, '0, 1'b0));
      send_req(mk_req(OP_LOOKUP, '0, '0, '0, 4'd7, 1'b1));
      // out-of-range handles
      send_req(mk_req(OP_LOOKUP, '0, '0, '0, 4'd15, 1'b1));
      send_req(mk_req(OP_DELETE, '0, '0, '0, 4'd8, 1'b1));
      send_req(mk_req(OP_DELETE, '0, '0, '0, 4'd7, 1'b1));
      send_req(mk_req(OP_LOOKUP, '0, '0, '0, 4'd7, 1'b1));
      // fill the rest of the table, then hit it full with both allocating ops
      for (int k = 0; k < SLOTS - 1; k++)
         send_req(mk_req(OP_MATCH, 32'h0A00_0001 + k, 16'(k + 1), '0, '0, 1'b1));
      send_req(mk_req(OP_MATCH, 32'h0A00_00FF, 16'd1, '0, '0, 1'b1));
      send_req(mk_req(OP_OPEN, '0, '0, 8'h42, '0, 1'b1));
      send_req(mk_req(OP_OPEN, '0, '0, 8'd0, '0, 1'b1));
      send_req(mk_req(OP_DELETE, '0, '0, '0, 4'd0, 1'b1));
      drain;
   endtask

   task automatic test_config_extremes;
      set_config(16'h0000, 32'h0000_0000);
      send_req(mk_req(OP_OPEN, '0, '0, 8'h81, '0, 1'b1));
      send_req(mk_req(OP_LOOKUP, '0, '0, '0, 4'd0, 1'b1));
      send_req(mk_req(OP_OPEN, '0, '0, 8'h81, '0, 1'b1));
      set_config(16'hFFFF, 32'hFFFF_FFFF);
      send_req(mk_req(OP_DELETE, '0, '0, '0, 4'd2, 1'b1));
      // base with a nonzero low octet: stored octet differs from the node
      send_req(mk_req(OP_OPEN, '0, '0, 8'h10, '0, 1'b1));
      send_req(mk_req(OP_OPEN, '0, '0, 8'h10, '0, 1'b1));
      send_req(mk_req(OP_LOOKUP, '0, '0, '0, 4'd2, 1'b1));
      set_config(RESET_PORT, RESET_BASE);
      for (int k = 0; k < SLOTS; k++)
         send_req(mk_req(OP_DELETE, '0, '0, '0, 4'(k), 1'b1));
      drain;
   endtask

   task automatic test_random_phase(input int beats);
      refresh_pools();
      repeat (beats) send_req(random_req());
      drain;
   endtask

   task automatic test_random;
      logic [15:0] port;
      logic [31:0] base;
      for (int phase = 0; phase < 7; phase++) begin
         port = 16'($urandom);
         base = {$urandom_range(0, 255) == 0 ? 8'hFF : 8'($urandom), 16'($urandom), 8'h00};
         case ($urandom_range(0, 3))
            0: begin
               port = '0;
               base = '0;
            end
            1: begin
               port = 16'hFFFF;
               base = 32'hFFFF_FF00;
            end
            default: ;
         endcase
         if ($urandom_range(0, 5) == 0)
            base[7:0] = 8'($urandom);
         set_config(port, base);
         test_random_phase(200);
      end
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering beats, so the block backs up into req_stall.
   task automatic test_backpressure;
      fork
         begin
            @(posedge clock);
            hold_off = 1'b1;
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      refresh_pools();
      repeat (40) send_req(random_req());
      drain;
   endtask

   task automatic test_no_idle;
      idle_off = 1'b1;
      set_config(RESET_PORT, RESET_BASE);
      test_random_phase(200);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++)
         peer_tab[i] = '0;
      cfg_shadow.default_port = RESET_PORT;
      cfg_shadow.subnet_base = RESET_BASE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_config_extremes();
      test_random();
      test_backpressure();
      test_no_idle();

      // Let any stray beat show up before judging
      drain;
      repeat (40) @(negedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
